// File: rtl/nearest_neighbor_image_scaler_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the image scaler
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_DEFINES_SVH

// Same-cycle implication
`define NNIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define NNIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Widths, codes and divider handshake types of the image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

   localparam int COORD_W    = 8;
   localparam int COLOR_W    = 8;
   localparam int PIX_W      = 3 * COLOR_W;
   localparam int REG_W      = 9;
   localparam int PROD_W     = COORD_W + REG_W;
   localparam int QUO_W      = 9;
   localparam int REQ_DATA_W = 2 * COORD_W + PIX_W;
   localparam int RSP_DATA_W = PIX_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [REG_W-1:0] REG_RESET = 9'd256;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_FETCH = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   // Divider command: start pulse with operands
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [REG_W-1:0]  divisor;
   } div_req_type;

   // Divider status: done pulse with quotient
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/nnis_ram.sv
// ----------------------------------------------------------------------------
// nnis_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nnis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/nnis_divider.sv
// ----------------------------------------------------------------------------
// nnis_divider
// Restoring divider, one quotient bit per cycle, QUO_W bits per quotient.
// The caller guarantees the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module nnis_divider
   import nnis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REG_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [REG_W-1:0] divisor_ff, divisor_in;

   logic [REG_W:0]   trial;
   logic [REG_W:0]   diff;
   logic             fits;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         // Upper dividend bits are already below the divisor
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(QUO_W);
         rem_in     = REG_W'(div_req.dividend[PROD_W-1:QUO_W]);
         quo_in     = div_req.dividend[QUO_W-1:0];
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REG_W-1:0] : trial[REG_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/nearest_neighbor_image_scaler_unit.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler: a load gives no result, so loads stream one per cycle
// while idle. A fetch inside the output runs two 9-step passes of the shared divider
// (column, then row), then a store read, skipped when the mapped source lies outside
// the frame. One outside the output responds in the cycle after the transfer. After a
// fetch the request side is held until its response is taken.
// Synchronous reset: registers to 256, sequencer idle; the image is undefined.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_scaler_unit_defines.svh"

module nearest_neighbor_image_scaler_unit
   import nnis_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // x_pos, y_pos, red_in, green_in, blue_in
   input  logic                  req_tuser,  // mode
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // red_out, green_out, blue_out
   output logic                  rsp_tuser,  // out_of_range
   // Register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_data
);

   // Coordinates never exceed 255, so only that part of the frame is stored
   localparam int COLS        = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int ROWS        = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int STORE_DEPTH = COLS * ROWS;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVX,
      S_DIVY,
      S_READ,
      S_CAPT,
      S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic                  div_start_ff, div_start_in;
   logic [PROD_W-1:0]     prod_x_ff, prod_x_in;
   logic [PROD_W-1:0]     prod_y_ff, prod_y_in;
   logic [QUO_W-1:0]      sx_ff, sx_in;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tuser_ff, rsp_tuser_in;

   logic [REG_W-1:0]      src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;

   logic [COORD_W-1:0]    x_pos, y_pos;
   logic [COLOR_W-1:0]    red_in, green_in, blue_in;
   mode_type              mode;
   logic                  req_fire;
   logic                  load_ok;
   logic                  fetch_ok;
   logic [QUO_W-1:0]      sy;
   logic                  src_ok;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         map_addr;
   logic [PIX_W-1:0]      ram_rd_data;
   logic                  ram_rd_en;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // Unpack the request
   assign x_pos    = req_tdata[COORD_W-1:0];
   assign y_pos    = req_tdata[2*COORD_W-1:COORD_W];
   assign red_in   = req_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];
   assign green_in = req_tdata[2*COORD_W+2*COLOR_W-1:2*COORD_W+COLOR_W];
   assign blue_in  = req_tdata[REQ_DATA_W-1:2*COORD_W+2*COLOR_W];
   assign mode     = mode_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_ready  = 1'b1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= REG_RESET;
         src_height_ff <= REG_RESET;
         dst_width_ff  <= REG_RESET;
         dst_height_ff <= REG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Drop loads outside the source frame or the store
   assign load_ok = ({1'b0, x_pos} < src_width_ff) && ({1'b0, y_pos} < src_height_ff) &&
                    (32'(x_pos) < MAX_WIDTH) && (32'(y_pos) < MAX_HEIGHT);
   assign wr_addr = AW'(32'(y_pos) * COLS + 32'(x_pos));

   // Fetch is served only inside the output size
   assign fetch_ok = ({1'b0, x_pos} < dst_width_ff) && ({1'b0, y_pos} < dst_height_ff);

   // Check the mapped source pixel once the row quotient arrives
   assign sy     = div_rsp.quotient;
   assign src_ok = (sx_ff < src_width_ff) && (sy < src_height_ff) &&
                   (32'(sx_ff) < MAX_WIDTH) && (32'(sy) < MAX_HEIGHT);
   // Columns past the store were never written; any address will do there
   assign map_addr = ((32'(sx_ff) < COLS) && (32'(sy) < ROWS)) ?
                     AW'(32'(sy) * COLS + 32'(sx_ff)) : '0;

   // Shared divider: column pass, then row pass
   assign div_req.start    = div_start_ff;
   assign div_req.dividend = (state_ff == S_DIVY) ? prod_y_ff : prod_x_ff;
   assign div_req.divisor  = (state_ff == S_DIVY) ? dst_height_ff : dst_width_ff;

   nnis_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign ram_rd_en = (state_ff == S_READ);

   // Store pixels in response order, red in the low byte
   nnis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire && (mode == MODE_LOAD) && load_ok),
      .wr_addr (wr_addr),
      .wr_data ({blue_in, green_in, red_in}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      div_start_in = 1'b0;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      sx_in        = sx_ff;
      rd_addr_in   = rd_addr_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (mode == MODE_FETCH)) begin
               if (fetch_ok) begin
                  prod_x_in    = PROD_W'(x_pos) * PROD_W'(src_width_ff);
                  prod_y_in    = PROD_W'(y_pos) * PROD_W'(src_height_ff);
                  div_start_in = 1'b1;
                  state_in     = S_DIVX;
               end else begin
                  rsp_tdata_in = '0;
                  rsp_tuser_in = 1'b1;
                  state_in     = S_OUT;
               end
            end
         end
         S_DIVX: begin
            if (div_rsp.done) begin
               sx_in        = div_rsp.quotient;
               div_start_in = 1'b1;
               state_in     = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_rsp.done) begin
               if (src_ok) begin
                  rd_addr_in = map_addr;
                  state_in   = S_READ;
               end else begin
                  rsp_tdata_in = '0;
                  rsp_tuser_in = 1'b1;
                  state_in     = S_OUT;
               end
            end
         end
         S_READ: begin
            state_in = S_CAPT;
         end
         S_CAPT: begin
            rsp_tdata_in = ram_rd_data;
            rsp_tuser_in = 1'b0;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
      end
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      sx_ff        <= sx_in;
      rd_addr_ff   <= rd_addr_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // Checks
   `NNIS_ASSERT_NOW(a_no_accept_while_pending, rsp_tvalid, !req_tready,
      "request taken while a response is pending")
   `NNIS_ASSERT_NOW(a_done_in_divide, div_rsp.done,
      (state_ff == S_DIVX) || (state_ff == S_DIVY), "divider done outside a divide pass")
   `NNIS_ASSERT_NOW(a_bad_is_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0,
      "out-of-range response carries a nonzero pixel")
   `NNIS_ASSERT_NEXT(a_fetch_busy, req_fire && (mode == MODE_FETCH), !req_tready,
      "ready held high after a fetch transfer")

endmodule
